// ----- hdl/sca_pkg.sv -----
// ----------------------------------------------------------------------------
// sca_pkg
// shared constants and action codes of the saturating counter array
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int unsigned NUM_CELLS     = 1024;
  localparam int unsigned COUNTER_WIDTH = 4;
  localparam int unsigned ADDR_W        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  // transaction field widths
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned OPERAND_W = 4;
  localparam int unsigned VALUE_W   = 4;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 8;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [ACTION_W-1:0]      action_t;

  localparam action_t ACT_READ  = 3'd0;
  localparam action_t ACT_INC   = 3'd1;
  localparam action_t ACT_DEC   = 3'd2;
  localparam action_t ACT_SET   = 3'd3;
  localparam action_t ACT_CLEAR = 3'd4;

endpackage

// ----- hdl/sca_ram.sv -----
// ----------------------------------------------------------------------------
// sca_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/saturating_counter_array.sv -----
// ----------------------------------------------------------------------------
// saturating_counter_array
// array of small saturating counters kept in one ram, updated by
// read-modify-write with forwarding between consecutive transactions
// ----------------------------------------------------------------------------
// result path: update stage, then the output register
// throughput: one transaction per cycle, set by the single ram read/write pair,
//   while the output drains and no clear is pending
// clear all: result like any other, then a sweep zeroes every cell, with
//   in_tready low from the clear's acceptance until the sweep ends
// reset: synchronous, active low; a clearing sweep runs before input is taken
module saturating_counter_array (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // action [2:0], cell_index [12:3], operand_value [16:13], zero fill
  input  logic [sca_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cell_value [3:0], ok [4], zero fill
  output logic [sca_pkg::OUT_DATA_W-1:0]    out_tdata
);

  import sca_pkg::*;

  // top-level modes
  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic state_r, state_nxt;
  addr_t sweep_cnt_r, sweep_cnt_nxt;

  // input transaction fields
  action_t                in_action;
  logic [INDEX_W-1:0]     in_cell_index;
  logic [OPERAND_W-1:0]   in_operand_value;
  logic                   in_accept;
  logic                   in_in_range;
  addr_t                  in_addr;

  // update stage: ram data arrives here
  logic    s1_v_r, s1_v_nxt;
  action_t s1_act_r;
  addr_t   s1_addr_r;
  logic    s1_inr_r;
  cnt_t    s1_opnd_r;
  logic    s1_done;
  logic    s1_wr;

  // forwarding of the value written by the previous transaction
  logic fwd_r;
  cnt_t fwd_val_r;

  // output register
  logic                   out_v_r, out_v_nxt;
  logic [VALUE_W-1:0]     out_value_r;
  logic                   out_ok_r;

  // ram ports
  logic  ram_we;
  addr_t ram_waddr;
  cnt_t  ram_wdata;
  cnt_t  ram_rdata;

  // update arithmetic
  cnt_t                   cur;
  logic [COUNTER_WIDTH:0] sum;
  cnt_t                   new_val;
  logic                   new_ok;
  logic [VALUE_W-1:0]     res_value;
  logic                   res_ok;

  assign in_action        = in_tdata[2:0];
  assign in_cell_index    = in_tdata[12:3];
  assign in_operand_value = in_tdata[16:13];
  assign in_addr          = ADDR_W'(in_cell_index);
  assign in_in_range      = 32'(in_cell_index) < 32'(NUM_CELLS);

  // update stage retires when the output register is free or being drained
  assign s1_done = s1_v_r && (!out_v_r || out_tready);
  // only in-range, non-clear transactions write their cell back
  assign s1_wr   = s1_done && s1_inr_r && (s1_act_r != ACT_CLEAR);

  // a clear holds off new work until its sweep has finished
  assign in_tready = (state_r == ST_RUN)
                   && (!s1_v_r || (s1_done && (s1_act_r != ACT_CLEAR)));
  assign in_accept = in_tvalid && in_tready;

  sca_ram #(
    .WIDTH (COUNTER_WIDTH),
    .DEPTH (NUM_CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // current value: forwarded when the previous transaction just wrote this cell
  assign cur = fwd_r ? fwd_val_r : ram_rdata;
  assign sum = {1'b0, cur} + {1'b0, s1_opnd_r};

  always_comb begin
    new_val = cur;
    new_ok  = 1'b1;
    case (s1_act_r)
      ACT_INC: begin
        if (sum[COUNTER_WIDTH]) begin
          new_val = '1;
          new_ok  = 1'b0;
        end else begin
          new_val = sum[COUNTER_WIDTH-1:0];
        end
      end
      ACT_DEC: begin
        new_val = cur - s1_opnd_r;
        new_ok  = !(s1_opnd_r > cur);
      end
      ACT_SET: begin
        new_val = s1_opnd_r;
      end
      default: begin
        // read and unused codes leave the cell as it is
        new_val = cur;
      end
    endcase
  end

  always_comb begin
    if (s1_act_r == ACT_CLEAR) begin
      res_value = '0;
      res_ok    = 1'b1;
    end else if (!s1_inr_r) begin
      res_value = '0;
      res_ok    = 1'b0;
    end else begin
      res_value = VALUE_W'(new_val);
      res_ok    = new_ok;
    end
  end

  // write port: sweep zeroes cells, otherwise the update stage writes back
  always_comb begin
    if (state_r == ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_wr;
      ram_waddr = s1_addr_r;
      ram_wdata = new_val;
    end
  end

  // mode and sweep counter
  always_comb begin
    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    case (state_r)
      ST_RUN: begin
        if (s1_done && (s1_act_r == ACT_CLEAR)) begin
          state_nxt     = ST_SWEEP;
          sweep_cnt_nxt = '0;
        end
      end
      ST_SWEEP: begin
        sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        if (sweep_cnt_r == ADDR_W'(NUM_CELLS - 1)) begin
          state_nxt     = ST_RUN;
          sweep_cnt_nxt = '0;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_done) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_done) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_cnt_r <= '0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      s1_v_r      <= s1_v_nxt;
      out_v_r     <= out_v_nxt;
      if (in_accept) begin
        fwd_r <= s1_wr && (s1_addr_r == in_addr);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_act_r  <= in_action;
      s1_addr_r <= in_addr;
      s1_inr_r  <= in_in_range;
      s1_opnd_r <= COUNTER_WIDTH'(in_operand_value);
    end
    if (s1_wr) begin
      fwd_val_r <= new_val;
    end
    if (s1_done) begin
      out_value_r <= res_value;
      out_ok_r    <= res_ok;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W - VALUE_W - 1){1'b0}}, out_ok_r, out_value_r};

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the saturating counter array: requests go in on the input stream, a
// cycle-free predictor keeps its own image of every counter and queues the
// value and flag each request should return; every result transaction is
// compared against the oldest queued entry, under random gaps on both sides
// and one long output hold-off
// ----------------------------------------------------------------------------
module tb;

  import sca_pkg::*;

  // action codes with no function of their own, handled as a read
  localparam action_t ACT_SPARE_LO = 3'd5;
  localparam action_t ACT_SPARE_HI = 3'd7;

  // cycles to wait after the last result before finishing
  localparam int unsigned SETTLE_CYCLES = 20;
  // run limit in ns, far above the slowest legal run
  localparam longint unsigned RUN_LIMIT_NS = 64'd10_000_000;

  typedef logic [OPERAND_W-1:0] operand_t;

  // one expected result transaction
  typedef struct packed {
    cnt_t cell_value;
    logic ok;
  } counter_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  cnt_t            counter_image [NUM_CELLS];
  counter_result_t pending_results [$];
  int unsigned     fail_count = 0;
  bit              idle_on = 1'b0;
  int unsigned     hold_off_left = 0;
  int unsigned     stall_left = 0;
  addr_t           hot_cells [6];

  saturating_counter_array dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // updates the counter image for one request and returns its result
  function automatic counter_result_t apply_request(action_t act, addr_t idx, operand_t opnd);
    counter_result_t res;
    cnt_t            cur;
    logic [COUNTER_WIDTH:0] sum;
    res.cell_value = '0;
    res.ok = 1'b1;
    if (act == ACT_CLEAR) begin
      foreach (counter_image[i]) counter_image[i] = '0;
    end else if (int'(idx) >= int'(NUM_CELLS)) begin
      res.ok = 1'b0;
    end else begin
      cur = counter_image[idx];
      case (act)
        ACT_INC: begin
          sum = {1'b0, cur} + {1'b0, cnt_t'(opnd)};
          if (sum[COUNTER_WIDTH]) begin
            cur = '1;
            res.ok = 1'b0;
          end else begin
            cur = sum[COUNTER_WIDTH-1:0];
          end
        end
        ACT_DEC: begin
          if (cnt_t'(opnd) > cur) res.ok = 1'b0;
          cur = cur - cnt_t'(opnd);
        end
        ACT_SET: begin
          cur = cnt_t'(opnd);
        end
        default: begin
        end
      endcase
      counter_image[idx] = cur;
      res.cell_value = cur;
    end
    return res;
  endfunction

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    counter_result_t want;
    if (rst_n && in_tvalid && in_tready) begin
      pending_results.push_back(apply_request(in_tdata[ACTION_W-1:0],
                                              in_tdata[ACTION_W +: INDEX_W],
                                              in_tdata[ACTION_W+INDEX_W +: OPERAND_W]));
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no request pending: tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[VALUE_W-1:0] !== want.cell_value) begin
          $error("cell_value: expected %0d, actual %0d", want.cell_value,
                 out_tdata[VALUE_W-1:0]);
          fail_count++;
        end
        if (out_tdata[VALUE_W] !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, out_tdata[VALUE_W]);
          fail_count++;
        end
      end
    end
  end

  // result side: long hold-off when asked, random stalls while idling is on
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_tready <= 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // offers one request and waits for its handshake, then maybe idles
  task automatic send_request(action_t act, addr_t idx, operand_t opnd);
    logic [IN_DATA_W-1:0] word;
    int unsigned          gap;
    word = '0;
    word[ACTION_W-1:0] = act;
    word[ACTION_W +: INDEX_W] = idx;
    word[ACTION_W+INDEX_W +: OPERAND_W] = opnd;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata <= IN_DATA_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // random request, biased to a few hot cells so counters hit their limits
  task automatic send_random_request();
    action_t     act;
    addr_t       idx;
    operand_t    opnd;
    int unsigned pick;
    if ($urandom_range(0, 3) != 0) idx = hot_cells[$urandom_range(0, 5)];
    else idx = addr_t'($urandom_range(0, NUM_CELLS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 2) act = ACT_CLEAR;
    else if (pick < 37) act = ACT_INC;
    else if (pick < 67) act = ACT_DEC;
    else if (pick < 79) act = ACT_SET;
    else if (pick < 91) act = ACT_READ;
    else act = action_t'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    if ((act == ACT_INC || act == ACT_DEC) && $urandom_range(0, 4) < 3)
      opnd = operand_t'($urandom_range(1, 3));
    else
      opnd = operand_t'($urandom_range(0, (1 << OPERAND_W) - 1));
    send_request(act, idx, opnd);
  endtask

  // every counter starts at zero once the clearing sweep is over
  task automatic test_after_reset();
    send_request(ACT_READ, '0, '0);
    send_request(ACT_READ, addr_t'(NUM_CELLS - 1), '1);
    send_request(ACT_READ, addr_t'($urandom_range(0, NUM_CELLS - 1)), '0);
  endtask

  // saturation, borrow, zero amounts, spare codes, clear all
  task automatic test_corner_cases();
    addr_t top;
    top = addr_t'(NUM_CELLS - 1);
    send_request(ACT_SET, top, '1);
    send_request(ACT_INC, top, '0);           // increment by zero leaves it alone
    send_request(ACT_INC, top, operand_t'(1)); // saturates at all ones
    send_request(ACT_DEC, '0, '0);            // decrement by zero, no borrow
    send_request(ACT_DEC, '0, operand_t'(1)); // borrow wraps around
    send_request(ACT_DEC, '0, '1);            // exact subtract down to zero
    send_request(ACT_INC, '0, '1);            // full-scale add without overflow
    send_request(ACT_SET, addr_t'(10'h155), operand_t'(4'h5));
    send_request(ACT_SET, addr_t'(10'h2aa), operand_t'(4'ha));
    send_request(ACT_INC, addr_t'(10'h155), operand_t'(4'ha));
    send_request(ACT_INC, addr_t'(10'h2aa), operand_t'(4'h6));
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) begin
      send_request(action_t'(a), top, operand_t'(a));
    end
    send_request(ACT_DEC, addr_t'(10'h155), operand_t'(4'h3));
    send_request(ACT_CLEAR, addr_t'(10'h2aa), '1);
    send_request(ACT_READ, top, '0);
    send_request(ACT_READ, '0, '0);
    send_request(ACT_DEC, addr_t'(10'h155), operand_t'(1));
  endtask

  // long random stream with gaps on both sides
  task automatic test_random_traffic(int unsigned count);
    hot_cells[0] = '0;
    hot_cells[1] = addr_t'(NUM_CELLS - 1);
    for (int i = 2; i < 6; i++) hot_cells[i] = addr_t'($urandom_range(0, NUM_CELLS - 1));
    idle_on = 1'b1;
    repeat (count) send_random_request();
  endtask

  // result side held off while requests keep coming, so the input backs up
  task automatic test_output_stall(int unsigned count);
    idle_on = 1'b0;
    hold_off_left = 300;
    repeat (count) send_random_request();
  endtask

  // full rate on both sides, no idling at all
  task automatic test_back_to_back(int unsigned count);
    idle_on = 1'b0;
    repeat (count) send_random_request();
  endtask

  initial begin : main_sequence
    foreach (counter_image[i]) counter_image[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_corner_cases();
    test_random_traffic(400);
    test_output_stall(40);
    test_back_to_back(100);
    test_random_traffic(90);

    @(negedge clk);
    in_tvalid <= 1'b0;
    idle_on = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
